FILE: rtl/olist_pkg.sv
// ----------------------------------------------------------------------------
// olist_pkg
// Shared codes, payload structs and controller/datapath handshake types for
// the ordered value list.
// ----------------------------------------------------------------------------
package olist_pkg;

   // Operation codes carried by a request transaction
   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_DUMP   = 2'd2;

   // Result kinds carried by a response transaction
   localparam logic [2:0] KIND_APPENDED  = 3'd0;
   localparam logic [2:0] KIND_FULL      = 3'd1;
   localparam logic [2:0] KIND_DELETED   = 3'd2;
   localparam logic [2:0] KIND_NOT_FOUND = 3'd3;
   localparam logic [2:0] KIND_ELEMENT   = 3'd4;
   localparam logic [2:0] KIND_EMPTY     = 3'd5;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic signed [31:0] item;
      logic               last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DEL_CMP,
      ST_SHIFT,
      ST_EMIT,
      ST_DUMP
   } state_type;

   // Read address select: current index, index + 1, index + 2
   typedef enum logic [1:0] {
      RD_CUR,
      RD_NEXT,
      RD_NEXT2
   } rd_sel_type;

   // Write select: append at tail, or shift one slot toward the head
   typedef enum logic {
      WR_TAIL,
      WR_SHIFT
   } wr_sel_type;

   typedef struct packed {
      logic       capture;
      logic       idx_clr;
      logic       idx_inc;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      wr_sel_type wr_sel;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       out_ld;
      logic [2:0] out_kind;
      logic       out_elem;
      logic       out_last;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       full;
      logic       empty;
      logic       match;
      logic       idx_last;
      logic       shift_more;
      logic       out_free;
   } sts_type;

endpackage

FILE: rtl/olist_stream_if.sv
// ----------------------------------------------------------------------------
// olist_stream_if
// Valid/ready channel carrying one payload struct per transaction.
// ----------------------------------------------------------------------------
interface olist_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/olist_ctrl.sv
// ----------------------------------------------------------------------------
// olist_ctrl
// Sequencer for the ordered list: decodes an operation, walks the table for
// delete and dump, and schedules response transactions.
// ----------------------------------------------------------------------------
module olist_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  olist_pkg::sts_type  sts,
   output olist_pkg::cmd_type  cmd
);
   import olist_pkg::*;

   state_type  state_ff, state_in;
   logic [2:0] kind_ff, kind_in;

   // State and pending result kind
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      kind_ff <= kind_in;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (sts.op)
               OP_APPEND: begin
                  state_in = ST_EMIT;
                  kind_in  = sts.full ? KIND_FULL : KIND_APPENDED;
               end
               OP_DELETE: begin
                  if (sts.empty) begin
                     state_in = ST_EMIT;
                     kind_in  = KIND_NOT_FOUND;
                  end else begin
                     state_in = ST_DEL_CMP;
                  end
               end
               OP_DUMP: begin
                  if (sts.empty) begin
                     state_in = ST_EMIT;
                     kind_in  = KIND_EMPTY;
                  end else begin
                     state_in = ST_DUMP;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_DEL_CMP: begin
            if (sts.match) begin
               if (sts.idx_last) begin
                  state_in = ST_EMIT;
                  kind_in  = KIND_DELETED;
               end else begin
                  state_in = ST_SHIFT;
               end
            end else if (sts.idx_last) begin
               state_in = ST_EMIT;
               kind_in  = KIND_NOT_FOUND;
            end
         end
         ST_SHIFT: begin
            if (!sts.shift_more) begin
               state_in = ST_EMIT;
               kind_in  = KIND_DELETED;
            end
         end
         ST_DUMP: begin
            if (sts.out_free && sts.idx_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Commands to the datapath
   always_comb begin
      cmd          = '0;
      cmd.rd_sel   = RD_CUR;
      cmd.wr_sel   = WR_TAIL;
      cmd.out_kind = kind_ff;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            cmd.idx_clr = req_valid;
         end
         ST_DECODE: begin
            case (sts.op)
               OP_APPEND: begin
                  if (!sts.full) begin
                     cmd.wr_en   = 1'b1;
                     cmd.wr_sel  = WR_TAIL;
                     cmd.cnt_inc = 1'b1;
                  end
               end
               OP_DELETE, OP_DUMP: begin
                  cmd.rd_en  = !sts.empty;
                  cmd.rd_sel = RD_CUR;
               end
               default: begin
               end
            endcase
         end
         ST_DEL_CMP: begin
            if (sts.match) begin
               if (sts.idx_last) begin
                  cmd.cnt_dec = 1'b1;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_NEXT;
               end
            end else if (!sts.idx_last) begin
               cmd.idx_inc = 1'b1;
               cmd.rd_en   = 1'b1;
               cmd.rd_sel  = RD_NEXT;
            end
         end
         ST_SHIFT: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WR_SHIFT;
            cmd.idx_inc = 1'b1;
            if (sts.shift_more) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_NEXT2;
            end else begin
               cmd.cnt_dec = 1'b1;
            end
         end
         ST_DUMP: begin
            if (sts.out_free) begin
               cmd.out_ld   = 1'b1;
               cmd.out_kind = KIND_ELEMENT;
               cmd.out_elem = 1'b1;
               cmd.out_last = sts.idx_last;
               if (!sts.idx_last) begin
                  cmd.idx_inc = 1'b1;
                  cmd.rd_en   = 1'b1;
                  cmd.rd_sel  = RD_NEXT;
               end
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.out_ld   = 1'b1;
               cmd.out_last = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

FILE: rtl/olist_dp.sv
// ----------------------------------------------------------------------------
// olist_dp
// Datapath: entry memory, entry count, walk index, captured request and the
// response output register.
// ----------------------------------------------------------------------------
module olist_dp #(
   parameter int CAPACITY = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  olist_pkg::req_type req_payload,
   input  olist_pkg::cmd_type cmd,
   output olist_pkg::sts_type sts,
   olist_stream_if.source     rsp
);
   import olist_pkg::*;

   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam logic [CNT_W:0] CAP_EXT = (CNT_W + 1)'(CAPACITY);

   logic signed [31:0] entry_mem_ff [CAPACITY];
   logic signed [31:0] rdata_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   req_type            req_ff;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CNT_W:0]     idx_ext, count_ext;
   logic [CNT_W:0]     rd_idx;
   logic [ADDR_W-1:0]  rd_addr, wr_addr;
   logic signed [31:0] wr_data;

   assign idx_ext   = {1'b0, idx_ff};
   assign count_ext = {1'b0, count_ff};

   // Address and data selection
   always_comb begin
      case (cmd.rd_sel)
         RD_CUR:   rd_idx = idx_ext;
         RD_NEXT:  rd_idx = idx_ext + (CNT_W + 1)'(1);
         RD_NEXT2: rd_idx = idx_ext + (CNT_W + 1)'(2);
         default:  rd_idx = idx_ext;
      endcase
      rd_addr = rd_idx[ADDR_W-1:0];
      if (cmd.wr_sel == WR_SHIFT) begin
         wr_addr = idx_ff[ADDR_W-1:0];
         wr_data = rdata_ff;
      end else begin
         wr_addr = count_ff[ADDR_W-1:0];
         wr_data = req_ff.value;
      end
   end

   // Entry memory, registered read
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rdata_ff <= entry_mem_ff[rd_addr];
      end
   end

   // Count and walk index
   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CNT_W'(1);
      end
      idx_in = idx_ff;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_payload;
      end
   end

   // Response output register
   assign rsp_valid_in = cmd.out_ld ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.out_ld) begin
         rsp_ff.kind <= cmd.out_kind;
         rsp_ff.item <= cmd.out_elem ? rdata_ff : 32'sd0;
         rsp_ff.last <= cmd.out_last;
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   // Status to the controller
   always_comb begin
      sts.op         = req_ff.op;
      sts.full       = (count_ext >= CAP_EXT);
      sts.empty      = (count_ff == '0);
      sts.match      = (rdata_ff == req_ff.value);
      sts.idx_last   = ((idx_ext + (CNT_W + 1)'(1)) >= count_ext);
      sts.shift_more = ((idx_ext + (CNT_W + 1)'(2)) < count_ext);
      sts.out_free   = !rsp_valid_ff || rsp.ready;
   end

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ext <= CAP_EXT)
      else $error("entry count above capacity");

   a_no_append_full: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_inc |-> !sts.full)
      else $error("append into a full list");

   a_no_dec_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_dec |-> !sts.empty)
      else $error("delete from an empty list");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_ld |-> sts.out_free)
      else $error("response overwritten before it was taken");

endmodule

FILE: rtl/ordered_list_append_delete_by_value.sv
// ----------------------------------------------------------------------------
// ordered_list_append_delete_by_value
// Bounded ordered list of signed 32-bit values with append, delete-by-value
// and dump operations; a sequencer drives a memory-based datapath.
// ----------------------------------------------------------------------------
//  channel | dir | fields              | transactions per request
//  --------+-----+---------------------+--------------------------------------
//  req     | in  | op, value           | one
//  rsp     | out | kind, item, last    | one, or one per entry on dump
//
//  Append steps through accept, decode and load to its response. Delete makes
//  one compare per entry up to the match on the single memory read port, then
//  one shift write per following entry. Dump gives one element per cycle while
//  rsp is ready. A new request is taken while the last response still waits in
//  the output register; a stalled rsp holds the dump walk. Synchronous reset
//  empties the list.
// ----------------------------------------------------------------------------
module ordered_list_append_delete_by_value #(
   parameter int CAPACITY = 16
) (
   input  logic           clock,
   input  logic           reset,
   olist_stream_if.sink   req,
   olist_stream_if.source rsp
);
   import olist_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    ctl_req_ready;

   assign req.ready = ctl_req_ready;

   // Sequencer
   olist_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (ctl_req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Storage and response register
   olist_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req.payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp         (rsp)
   );

endmodule
